FILE: rtl/core/mcc_pkg.sv
package mcc_pkg;

  localparam int MEM_WORDS = 65536;
  localparam int ADDR_W    = $clog2(MEM_WORDS);

  typedef struct packed {
    logic               kind;
    logic [15:0]        load_address;
    logic signed [31:0] load_word;
  } in_item_t;

  typedef struct packed {
    logic [4:0]         state_code;
    logic [1:0]         run_status;
    logic signed [31:0] program_counter;
    logic signed [31:0] instruction;
    logic signed [31:0] bus_value;
    logic               memory_ready;
  } out_item_t;

  typedef enum logic [4:0] {
    S_FETCH   = 5'd0,
    S_FETCH2  = 5'd1,
    S_DECODE1 = 5'd2,
    S_DECODE2 = 5'd3,
    S_ADD1    = 5'd4,
    S_NAND1   = 5'd5,
    S_ALUFIN  = 5'd6,
    S_LW1     = 5'd7,
    S_LW2     = 5'd8,
    S_LW3     = 5'd9,
    S_LW4     = 5'd10,
    S_SW1     = 5'd11,
    S_SW2     = 5'd12,
    S_SW3     = 5'd13,
    S_SW4     = 5'd14,
    S_BEQ1    = 5'd15,
    S_BEQ2    = 5'd16,
    S_BEQ3    = 5'd17,
    S_BEQ4    = 5'd18,
    S_JALR1   = 5'd19,
    S_JALR2   = 5'd20,
    S_HALT    = 5'd21
  } ctrl_state_t;

  typedef enum logic [1:0] {
    SEQ_CLEAR,
    SEQ_IDLE,
    SEQ_EXEC,
    SEQ_MEMWAIT
  } seq_state_t;

  typedef enum logic [1:0] {
    RUN_OK       = 2'd0,
    RUN_HALTED   = 2'd1,
    RUN_BAD_ADDR = 2'd2,
    RUN_BAD_OP   = 2'd3
  } run_status_t;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_NAND = 3'd1,
    OP_LW   = 3'd2,
    OP_SW   = 3'd3,
    OP_BEQ  = 3'd4,
    OP_JALR = 3'd5,
    OP_HALT = 3'd6,
    OP_NOOP = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    BUS_NONE,
    BUS_PC,
    BUS_DATA,
    BUS_REG,
    BUS_ALU,
    BUS_OFFSET
  } bus_src_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_NAND,
    ALU_SUB
  } alu_op_t;

  typedef enum logic {
    REG_A,
    REG_B
  } reg_sel_t;

  typedef enum logic {
    DST_DEST,
    DST_B
  } wr_dst_t;

  typedef struct packed {
    logic        accept;
    logic        clear_write;
    logic        load_write;
    bus_src_t    bus_src;
    reg_sel_t    reg_sel;
    wr_dst_t     wr_dst;
    alu_op_t     alu_op;
    logic        ld_addr;
    logic        pc_inc;
    logic        ld_pc;
    logic        ld_instr;
    logic        ld_operand;
    logic        ld_result;
    logic        ld_data;
    logic        reg_write;
    logic        mem_acc;
    logic        mem_read;
    logic        mem_capture;
    logic        out_load;
    ctrl_state_t out_code;
    run_status_t out_status;
    logic        out_ready;
  } dp_cmd_t;

  typedef struct packed {
    logic    kind;
    logic    op_bad;
    opcode_t op;
    logic    alu_zero;
    logic    addr_bad;
    logic    acc_done;
    logic    clear_last;
    logic    out_free;
  } dp_status_t;

  // residue mod 3 from base-4 digit sum
  function automatic logic [1:0] mod3_16(input logic [15:0] v);
    logic [4:0] s;
    logic [3:0] t;
    logic [2:0] u;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 4'(s[4:2]) + 4'(s[1:0]);
    u = 3'(t[3:2]) + 3'(t[1:0]);
    if (u >= 3'd3) begin
      u = u - 3'd3;
    end
    return u[1:0];
  endfunction

endpackage

FILE: rtl/core/multicycle_cpu_controller_unit.sv
// channel   signals                              payload
// item      item_valid, item_stall, item         load word or execute one control state
// result    result_valid, result_stall, result   state, status, pc, instruction, bus, ready
//
// a transaction is accepted, then executes one control state once the output register is free
// a completed memory read adds a memory-wait state for the registered word memory read
// after reset all 65536 words of the word memory are cleared with item_stall high
// a result waits in the output register while result_stall is high
module multicycle_cpu_controller_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  mcc_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_stall,
  output mcc_pkg::out_item_t result
);
  import mcc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mcc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .cmd         (cmd),
    .status      (status),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

endmodule

FILE: rtl/core/mcc_ram.sv
module mcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/mcc_datapath.sv
module mcc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  mcc_pkg::in_item_t   item,
  input  mcc_pkg::dp_cmd_t    cmd,
  output mcc_pkg::dp_status_t status,
  output logic                result_valid,
  input  logic                result_stall,
  output mcc_pkg::out_item_t  result
);
  import mcc_pkg::*;

  in_item_t          item_reg;
  logic [31:0]       pc;
  logic [31:0]       addr_reg;
  logic [31:0]       data_reg;
  logic [31:0]       instr_reg;
  logic [31:0]       operand;
  logic [31:0]       alu_res;
  logic [31:0]       regs [8];
  logic [1:0]        access_delay;
  logic              la_valid;
  logic [ADDR_W-1:0] la_addr;
  logic              la_read;
  logic [31:0]       la_data;
  logic [ADDR_W-1:0] clear_cnt;

  logic [31:0]       bus;
  logic [2:0]        rd_idx;
  logic [2:0]        wr_idx;
  logic [31:0]       alu_out;
  logic [31:0]       pc_next;
  logic [31:0]       instr_next;
  logic [ADDR_W-1:0] a_low;
  logic              addr_bad;
  logic              is_new;
  logic [1:0]        delay_eff;
  logic              acc_done;
  logic              acc_go;
  logic              load_ok;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [31:0]       ram_wdata;
  logic              ram_re;
  logic [31:0]       ram_rdata;

  assign rd_idx = (cmd.reg_sel == REG_A) ? instr_reg[21:19] : instr_reg[18:16];
  assign wr_idx = (cmd.wr_dst == DST_B) ? instr_reg[18:16] : instr_reg[2:0];

  always_comb begin
    case (cmd.bus_src)
      BUS_PC:     bus = pc;
      BUS_DATA:   bus = data_reg;
      BUS_REG:    bus = regs[rd_idx];
      BUS_ALU:    bus = alu_res;
      BUS_OFFSET: bus = {{16{instr_reg[15]}}, instr_reg[15:0]};
      default:    bus = '0;
    endcase
  end

  always_comb begin
    case (cmd.alu_op)
      ALU_ADD:  alu_out = operand + bus;
      ALU_NAND: alu_out = ~(operand & bus);
      ALU_SUB:  alu_out = operand - bus;
      default:  alu_out = operand + bus;
    endcase
  end

  assign pc_next    = cmd.ld_pc ? bus : (cmd.pc_inc ? pc + 32'd1 : pc);
  assign instr_next = cmd.ld_instr ? bus : instr_reg;

  // memory access timing
  assign a_low     = addr_reg[ADDR_W-1:0];
  assign addr_bad  = addr_reg >= 32'(MEM_WORDS);
  assign is_new    = !la_valid || (la_addr != a_low) || (la_read != cmd.mem_read) ||
                     (!cmd.mem_read && (la_data != data_reg));
  assign delay_eff = is_new ? mod3_16(16'(a_low)) : access_delay;
  assign acc_done  = delay_eff == 2'd0;
  assign acc_go    = cmd.mem_acc && !addr_bad;
  assign load_ok   = {1'b0, item_reg.load_address} < 17'(MEM_WORDS);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = a_low;
    ram_wdata = data_reg;
    if (cmd.clear_write) begin
      ram_we    = 1'b1;
      ram_waddr = clear_cnt;
      ram_wdata = '0;
    end else if (cmd.load_write) begin
      ram_we    = load_ok;
      ram_waddr = item_reg.load_address[ADDR_W-1:0];
      ram_wdata = item_reg.load_word;
    end else if (acc_go && acc_done && !cmd.mem_read) begin
      ram_we = 1'b1;
    end
  end

  assign ram_re = acc_go && acc_done && cmd.mem_read;

  mcc_ram #(
    .WIDTH(32),
    .DEPTH(MEM_WORDS)
  ) u_word_mem (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(a_low),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_reg <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= '0;
      addr_reg     <= '0;
      data_reg     <= '0;
      instr_reg    <= '0;
      operand      <= '0;
      alu_res      <= '0;
      regs         <= '{default: '0};
      access_delay <= '0;
      la_valid     <= 1'b0;
      la_addr      <= '0;
      la_read      <= 1'b0;
      la_data      <= '0;
      clear_cnt    <= '0;
    end else begin
      pc        <= pc_next;
      instr_reg <= instr_next;
      if (cmd.ld_addr) begin
        addr_reg <= bus;
      end
      if (cmd.mem_capture) begin
        data_reg <= ram_rdata;
      end else if (cmd.ld_data) begin
        data_reg <= bus;
      end
      if (cmd.ld_operand) begin
        operand <= bus;
      end
      if (cmd.ld_result) begin
        alu_res <= alu_out;
      end
      if (cmd.reg_write) begin
        regs[wr_idx] <= bus;
      end
      if (acc_go) begin
        access_delay <= acc_done ? 2'd0 : delay_eff - 2'd1;
        if (is_new) begin
          la_valid <= 1'b1;
          la_addr  <= a_low;
          la_read  <= cmd.mem_read;
          la_data  <= data_reg;
        end
      end
      if (cmd.clear_write) begin
        clear_cnt <= clear_cnt + ADDR_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.state_code      <= cmd.out_code;
      result.run_status      <= cmd.out_status;
      result.program_counter <= pc_next;
      result.instruction     <= instr_next;
      result.bus_value       <= bus;
      result.memory_ready    <= cmd.out_ready;
    end
  end

  assign status.kind       = item_reg.kind;
  assign status.op_bad     = instr_reg[31:22] > 10'd7;
  assign status.op         = opcode_t'(instr_reg[24:22]);
  assign status.alu_zero   = alu_res == 32'd0;
  assign status.addr_bad   = addr_bad;
  assign status.acc_done   = acc_done;
  assign status.clear_last = clear_cnt == ADDR_W'(MEM_WORDS - 1);
  assign status.out_free   = !result_valid || !result_stall;

endmodule

FILE: rtl/core/mcc_ctrl.sv
module mcc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  mcc_pkg::dp_status_t status,
  output mcc_pkg::dp_cmd_t    cmd
);
  import mcc_pkg::*;

  seq_state_t  seq;
  seq_state_t  seq_next;
  ctrl_state_t control_state;
  ctrl_state_t control_state_next;
  run_status_t machine_status;
  run_status_t machine_status_next;

  logic go;
  logic step_go;

  assign go         = (seq == SEQ_EXEC) && status.out_free;
  assign step_go    = go && status.kind && (machine_status == RUN_OK);
  assign item_stall = seq != SEQ_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      seq            <= SEQ_CLEAR;
      control_state  <= S_FETCH;
      machine_status <= RUN_OK;
    end else begin
      seq            <= seq_next;
      control_state  <= control_state_next;
      machine_status <= machine_status_next;
    end
  end

  // next state
  always_comb begin
    seq_next            = seq;
    control_state_next  = control_state;
    machine_status_next = machine_status;
    case (seq)
      SEQ_CLEAR: begin
        if (status.clear_last) begin
          seq_next = SEQ_IDLE;
        end
      end
      SEQ_IDLE: begin
        if (item_valid) begin
          seq_next = SEQ_EXEC;
        end
      end
      SEQ_EXEC: begin
        if (go) begin
          seq_next = SEQ_IDLE;
        end
        if (step_go) begin
          case (control_state)
            S_FETCH:   control_state_next = S_FETCH2;
            S_FETCH2, S_LW3, S_SW4: begin
              if (status.addr_bad) begin
                machine_status_next = RUN_BAD_ADDR;
              end else if (status.acc_done) begin
                if (control_state == S_SW4) begin
                  control_state_next = S_FETCH;
                end else begin
                  seq_next = SEQ_MEMWAIT;
                end
              end
            end
            S_DECODE1: control_state_next = S_DECODE2;
            S_DECODE2: begin
              if (status.op_bad) begin
                machine_status_next = RUN_BAD_OP;
              end else begin
                case (status.op)
                  OP_ADD:  control_state_next = S_ADD1;
                  OP_NAND: control_state_next = S_NAND1;
                  OP_LW:   control_state_next = S_LW1;
                  OP_SW:   control_state_next = S_SW1;
                  OP_BEQ:  control_state_next = S_BEQ1;
                  OP_JALR: control_state_next = S_JALR1;
                  OP_HALT: control_state_next = S_HALT;
                  default: control_state_next = S_FETCH;
                endcase
              end
            end
            S_ADD1:    control_state_next = S_ALUFIN;
            S_NAND1:   control_state_next = S_ALUFIN;
            S_ALUFIN:  control_state_next = S_FETCH;
            S_LW1:     control_state_next = S_LW2;
            S_LW2:     control_state_next = S_LW3;
            S_LW4:     control_state_next = S_FETCH;
            S_SW1:     control_state_next = S_SW2;
            S_SW2:     control_state_next = S_SW3;
            S_SW3:     control_state_next = S_SW4;
            S_BEQ1:    control_state_next = S_BEQ2;
            S_BEQ2:    control_state_next = status.alu_zero ? S_BEQ3 : S_FETCH;
            S_BEQ3:    control_state_next = S_BEQ4;
            S_BEQ4:    control_state_next = S_FETCH;
            S_JALR1:   control_state_next = S_JALR2;
            S_JALR2:   control_state_next = S_FETCH;
            S_HALT:    machine_status_next = RUN_HALTED;
            default:   control_state_next = S_FETCH;
          endcase
        end
      end
      SEQ_MEMWAIT: begin
        seq_next = SEQ_IDLE;
        control_state_next = (control_state == S_FETCH2) ? S_DECODE1 : S_LW4;
      end
      default: seq_next = SEQ_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd            = '0;
    cmd.bus_src    = BUS_NONE;
    cmd.reg_sel    = REG_A;
    cmd.wr_dst     = DST_DEST;
    cmd.alu_op     = ALU_ADD;
    cmd.out_code   = control_state;
    cmd.out_status = machine_status_next;
    case (seq)
      SEQ_CLEAR: cmd.clear_write = 1'b1;
      SEQ_IDLE:  cmd.accept = item_valid;
      SEQ_EXEC: begin
        if (go) begin
          cmd.out_load   = 1'b1;
          cmd.load_write = !status.kind;
        end
        if (step_go) begin
          case (control_state)
            S_FETCH: begin
              cmd.bus_src = BUS_PC;
              cmd.ld_addr = 1'b1;
              cmd.pc_inc  = 1'b1;
            end
            S_FETCH2, S_LW3, S_SW4: begin
              cmd.mem_acc  = 1'b1;
              cmd.mem_read = control_state != S_SW4;
              if (!status.addr_bad && status.acc_done) begin
                if (control_state == S_SW4) begin
                  cmd.out_ready = 1'b1;
                end else begin
                  cmd.out_load = 1'b0;
                end
              end
            end
            S_DECODE1: begin
              cmd.bus_src  = BUS_DATA;
              cmd.ld_instr = 1'b1;
            end
            S_DECODE2: begin
              cmd.reg_sel    = REG_A;
              cmd.bus_src    = BUS_REG;
              cmd.ld_operand = 1'b1;
            end
            S_ADD1, S_NAND1: begin
              cmd.reg_sel   = REG_B;
              cmd.bus_src   = BUS_REG;
              cmd.ld_result = 1'b1;
              cmd.alu_op    = (control_state == S_NAND1) ? ALU_NAND : ALU_ADD;
            end
            S_ALUFIN: begin
              cmd.bus_src   = BUS_ALU;
              cmd.wr_dst    = DST_DEST;
              cmd.reg_write = 1'b1;
            end
            S_LW1, S_SW1: begin
              cmd.bus_src   = BUS_OFFSET;
              cmd.ld_result = 1'b1;
            end
            S_LW2, S_SW2: begin
              cmd.bus_src = BUS_ALU;
              cmd.ld_addr = 1'b1;
            end
            S_LW4: begin
              cmd.bus_src   = BUS_DATA;
              cmd.wr_dst    = DST_B;
              cmd.reg_write = 1'b1;
            end
            S_SW3: begin
              cmd.reg_sel = REG_B;
              cmd.bus_src = BUS_REG;
              cmd.ld_data = 1'b1;
            end
            S_BEQ1: begin
              cmd.reg_sel   = REG_B;
              cmd.bus_src   = BUS_REG;
              cmd.alu_op    = ALU_SUB;
              cmd.ld_result = 1'b1;
            end
            S_BEQ2: begin
              cmd.bus_src    = BUS_OFFSET;
              cmd.ld_operand = 1'b1;
            end
            S_BEQ3: begin
              cmd.bus_src   = BUS_PC;
              cmd.ld_result = 1'b1;
            end
            S_BEQ4: begin
              cmd.bus_src = BUS_ALU;
              cmd.ld_pc   = 1'b1;
            end
            S_JALR1: begin
              cmd.bus_src   = BUS_PC;
              cmd.wr_dst    = DST_B;
              cmd.reg_write = 1'b1;
            end
            S_JALR2: begin
              cmd.reg_sel = REG_A;
              cmd.bus_src = BUS_REG;
              cmd.ld_pc   = 1'b1;
            end
            default: cmd.bus_src = BUS_NONE;
          endcase
        end
      end
      SEQ_MEMWAIT: begin
        cmd.mem_capture = 1'b1;
        cmd.out_load    = 1'b1;
        cmd.out_ready   = 1'b1;
      end
      default: cmd.bus_src = BUS_NONE;
    endcase
  end

  a_memwait_after_exec: assert property (@(posedge clk) disable iff (rst)
    (seq == SEQ_MEMWAIT) |-> $past(seq == SEQ_EXEC))
    else $error("memory wait not preceded by execute");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result loaded into a full output register");

  a_stopped_holds: assert property (@(posedge clk) disable iff (rst)
    (machine_status != RUN_OK) |=> (machine_status == $past(machine_status)))
    else $error("stopped machine changed status");

  a_state_moves_in_exec: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(control_state)) |->
      ($past(seq == SEQ_EXEC) || $past(seq == SEQ_MEMWAIT)))
    else $error("control state changed outside execution");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import mcc_pkg::*;

  localparam int LIMIT       = 400000;
  localparam int HOLD_CYCLES = 200;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_stall;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_item_t result;

  // machine state as seen by the testbench
  bit [31:0]   mem_img [MEM_WORDS];
  bit [31:0]   gpr [8];
  bit [31:0]   pc, mar, mdr, ir, operand, alu_res;
  ctrl_state_t ctrl = S_FETCH;
  run_status_t status = RUN_OK;
  bit [1:0]    wait_left;
  bit          acc_valid, acc_rd;
  bit [15:0]   acc_addr;
  bit [31:0]   acc_data;

  out_item_t step_results_q[$];
  int        items_sent, results_seen, errors, cycle_count, hold_len;
  bit        idle_en;

  multicycle_cpu_controller_unit DUT (
    .clk,
    .rst,
    .item_valid,
    .item_stall,
    .item,
    .result_valid,
    .result_stall,
    .result
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // returns 1 when done, 0 while waiting, -1 on a bad address
  function automatic int access_mem(bit rd);
    bit [15:0] a;
    a = mar[15:0];
    if (mar[31:16] != 16'd0) return -1;
    if (!acc_valid || acc_addr != a || acc_rd != rd || (!rd && acc_data != mdr)) begin
      wait_left = 2'(a % 3);
      acc_valid = 1'b1;
      acc_addr  = a;
      acc_rd    = rd;
      acc_data  = mdr;
    end
    if (wait_left == 2'd0) begin
      if (rd) mdr = mem_img[a];
      else mem_img[a] = mdr;
      return 1;
    end
    wait_left--;
    return 0;
  endfunction

  function automatic out_item_t cpu_step(in_item_t it);
    out_item_t   r;
    ctrl_state_t cur, nxt;
    bit [31:0]   bus, offs;
    bit          rdy;
    int          acc;
    cur  = ctrl;
    nxt  = cur;
    bus  = '0;
    rdy  = 1'b0;
    offs = {{16{ir[15]}}, ir[15:0]};
    if (!it.kind) begin
      mem_img[it.load_address] = it.load_word;
    end else if (status == RUN_OK) begin
      case (cur)
        S_FETCH: begin
          bus = pc;
          mar = bus;
          pc  = pc + 1;
          nxt = S_FETCH2;
        end
        S_FETCH2, S_LW3, S_SW4: begin
          acc = access_mem(cur != S_SW4);
          if (acc < 0) begin
            status = RUN_BAD_ADDR;
          end else if (acc > 0) begin
            rdy = 1'b1;
            nxt = (cur == S_FETCH2) ? S_DECODE1 : (cur == S_LW3) ? S_LW4 : S_FETCH;
          end
        end
        S_DECODE1: begin
          bus = mdr;
          ir  = bus;
          nxt = S_DECODE2;
        end
        S_DECODE2: begin
          bus     = gpr[ir[21:19]];
          operand = bus;
          if (ir[31:25] != 7'd0) begin
            status = RUN_BAD_OP;
          end else begin
            case (opcode_t'(ir[24:22]))
              OP_ADD:  nxt = S_ADD1;
              OP_NAND: nxt = S_NAND1;
              OP_LW:   nxt = S_LW1;
              OP_SW:   nxt = S_SW1;
              OP_BEQ:  nxt = S_BEQ1;
              OP_JALR: nxt = S_JALR1;
              OP_HALT: nxt = S_HALT;
              OP_NOOP: nxt = S_FETCH;
              default: nxt = S_FETCH;
            endcase
          end
        end
        S_ADD1: begin
          bus     = gpr[ir[18:16]];
          alu_res = operand + bus;
          nxt     = S_ALUFIN;
        end
        S_NAND1: begin
          bus     = gpr[ir[18:16]];
          alu_res = ~(operand & bus);
          nxt     = S_ALUFIN;
        end
        S_ALUFIN: begin
          bus           = alu_res;
          gpr[ir[2:0]]  = bus;
          nxt           = S_FETCH;
        end
        S_LW1, S_SW1: begin
          bus     = offs;
          alu_res = operand + bus;
          nxt     = (cur == S_LW1) ? S_LW2 : S_SW2;
        end
        S_LW2, S_SW2: begin
          bus = alu_res;
          mar = bus;
          nxt = (cur == S_LW2) ? S_LW3 : S_SW3;
        end
        S_LW4: begin
          bus             = mdr;
          gpr[ir[18:16]]  = bus;
          nxt             = S_FETCH;
        end
        S_SW3: begin
          bus = gpr[ir[18:16]];
          mdr = bus;
          nxt = S_SW4;
        end
        S_BEQ1: begin
          bus     = gpr[ir[18:16]];
          alu_res = operand - bus;
          nxt     = S_BEQ2;
        end
        S_BEQ2: begin
          bus     = offs;
          operand = bus;
          nxt     = (alu_res == 32'd0) ? S_BEQ3 : S_FETCH;
        end
        S_BEQ3: begin
          bus     = pc;
          alu_res = operand + bus;
          nxt     = S_BEQ4;
        end
        S_BEQ4: begin
          bus = alu_res;
          pc  = bus;
          nxt = S_FETCH;
        end
        S_JALR1: begin
          bus             = pc;
          gpr[ir[18:16]]  = bus;
          nxt             = S_JALR2;
        end
        S_JALR2: begin
          bus = gpr[ir[21:19]];
          pc  = bus;
          nxt = S_FETCH;
        end
        S_HALT: begin
          status = RUN_HALTED;
        end
        default: begin
          nxt = S_FETCH;
        end
      endcase
      ctrl = nxt;
    end
    r.state_code      = cur;
    r.run_status      = status;
    r.program_counter = pc;
    r.instruction     = ir;
    r.bus_value       = bus;
    r.memory_ready    = rdy;
    return r;
  endfunction

  function automatic bit [31:0] rand_word();
    case ($urandom_range(0, 2))
      0: return $urandom_range(0, 200);
      1: return $urandom_range(0, 65535);
      default: return $urandom;
    endcase
  endfunction

  function automatic opcode_t pick_op();
    int t;
    t = $urandom_range(0, 99);
    if (t < 20) return OP_LW;
    if (t < 40) return OP_SW;
    if (t < 55) return OP_ADD;
    if (t < 65) return OP_NAND;
    if (t < 80) return OP_BEQ;
    if (t < 92) return OP_JALR;
    return OP_NOOP;
  endfunction

  // random instruction that keeps the pc and data addresses in range
  function automatic bit [31:0] make_instr(opcode_t op, bit force_eq);
    bit [2:0]  ra, rb;
    bit [15:0] low;
    int        v, lo, hi, t, nxt_pc;
    int        cand[$];
    ra     = 3'($urandom);
    rb     = 3'($urandom);
    low    = 16'($urandom);
    nxt_pc = int'(pc) + 1;
    if (nxt_pc > 65535) begin
      op       = OP_BEQ;
      force_eq = 1'b1;
    end
    if (op == OP_LW || op == OP_SW) begin
      for (int i = 0; i < 8; i++) begin
        if ($signed(gpr[i]) >= -32767 && $signed(gpr[i]) <= 98302) cand.push_back(i);
      end
      if (cand.size() == 0) op = OP_JALR;
    end
    case (op)
      OP_LW, OP_SW: begin
        ra = 3'(cand[$urandom_range(0, cand.size() - 1)]);
        v  = $signed(gpr[ra]);
        lo = (v > 32768) ? v - 32768 : 0;
        hi = (v < 32768) ? v + 32767 : 65535;
        t  = $urandom_range(0, 11);
        if (t < lo || t > hi || $urandom_range(0, 1) == 1) begin
          t = lo + int'($urandom_range(0, hi - lo));
        end
        low = 16'(t - v);
      end
      OP_BEQ: begin
        if (force_eq) rb = ra;
        if (gpr[ra] == gpr[rb]) begin
          lo  = (nxt_pc > 32768) ? -32768 : -nxt_pc;
          hi  = (nxt_pc < 32768) ? 32767 : 65535 - nxt_pc;
          low = 16'(lo + int'($urandom_range(0, hi - lo)));
        end
      end
      OP_JALR: begin
        for (int i = 0; i < 8; i++) begin
          if (i != rb && gpr[i] <= 32'd65535) cand.push_back(i);
        end
        ra = (cand.size() == 0) ? rb : 3'(cand[$urandom_range(0, cand.size() - 1)]);
      end
      default: ;
    endcase
    return {7'd0, op, ra, rb, low};
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 30) begin
      $display("ERROR transaction %0d %s: got %h expected %h", results_seen, what, got, want);
    end
  endtask

  task automatic send_item(in_item_t it);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    step_results_q.push_back(cpu_step(it));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_load(bit [15:0] addr, bit [31:0] word);
    in_item_t it;
    it.kind         = 1'b0;
    it.load_address = addr;
    it.load_word    = word;
    send_item(it);
  endtask

  task automatic send_step();
    in_item_t it;
    it.kind         = 1'b1;
    it.load_address = 16'($urandom);
    it.load_word    = $urandom;
    send_item(it);
  endtask

  // place the instruction at the pc, then step until it retires or the machine stops
  task automatic run_instr(bit [31:0] word, bit noisy);
    if (noisy && $urandom_range(0, 2) == 0) begin
      send_load($urandom_range(0, 1) ? 16'($urandom_range(0, 11)) : 16'($urandom), rand_word());
    end
    send_load(pc[15:0], word);
    do begin
      if (noisy && ctrl != S_FETCH && ctrl != S_FETCH2 && $urandom_range(0, 9) == 0) begin
        send_load(16'($urandom), rand_word());
      end
      send_step();
    end while (status == RUN_OK && ctrl != S_FETCH);
  endtask

  task automatic test_directed();
    send_load(16'hFFFF, 32'h8000_0000);
    send_load(16'h0002, 32'h7FFF_FFFF);
    send_load(16'h0005, 32'hFFFF_FFFF);
    run_instr({7'd0, OP_LW, 3'd0, 3'd1, 16'h0002}, 1'b0);
    run_instr({7'd0, OP_SW, 3'd0, 3'd1, 16'h7FFF}, 1'b0);
  endtask

  task automatic test_each_op();
    opcode_t ops[7];
    ops = '{OP_ADD, OP_NAND, OP_LW, OP_SW, OP_BEQ, OP_JALR, OP_NOOP};
    // branch to itself, so the next fetch repeats the same read
    run_instr({7'd0, OP_BEQ, 3'd0, 3'd0, 16'hFFFF}, 1'b0);
    foreach (ops[i]) run_instr(make_instr(ops[i], 1'b0), 1'b0);
  endtask

  task automatic test_random_programs();
    idle_en = 1'b1;
    while (items_sent < 560) begin
      if ($urandom_range(0, 14) == 0) idle_en = !idle_en;
      run_instr(make_instr(pick_op(), $urandom_range(0, 2) == 0), 1'b1);
    end
  endtask

  task automatic test_backpressure();
    idle_en  = 1'b1;
    hold_len = HOLD_CYCLES;
    while (items_sent < 620) begin
      run_instr(make_instr(pick_op(), $urandom_range(0, 2) == 0), 1'b1);
    end
  endtask

  task automatic test_stop_machine();
    bit [31:0] word, addr;
    bit [2:0]  ra;
    bit [15:0] low;
    bit        found;
    int        pick;
    idle_en = 1'b0;
    while (items_sent < 680) begin
      run_instr(make_instr(pick_op(), $urandom_range(0, 2) == 0), 1'b1);
    end
    // halt, bad opcode, load or store out of range, or branch out of range
    pick  = $urandom_range(0, 4);
    ra    = 3'($urandom);
    found = 1'b0;
    low   = '0;
    for (int i = 0; i < 64 && !found; i++) begin
      low   = 16'($urandom);
      addr  = ((pick == 4) ? pc + 32'd1 : gpr[ra]) + {{16{low[15]}}, low};
      found = (addr[31:16] != 16'd0);
    end
    if (pick >= 2 && !found) pick = 0;
    case (pick)
      0: word = {7'd0, OP_HALT, 22'($urandom)};
      1: begin
        word        = $urandom;
        word[31:25] = 7'($urandom_range(1, 127));
      end
      2: word = {7'd0, OP_LW, ra, 3'($urandom), low};
      3: word = {7'd0, OP_SW, ra, 3'($urandom), low};
      default: word = {7'd0, OP_BEQ, ra, ra, low};
    endcase
    run_instr(word, 1'b0);
    while (status == RUN_OK) send_step();
    // the machine stays where it stopped
    repeat (8) begin
      if ($urandom_range(0, 2) == 0) send_load(16'($urandom), $urandom);
      else send_step();
    end
  endtask

  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        result_stall <= 1'b1;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
        result_stall <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (step_results_q.size() == 0) begin
        report("result with nothing expected", 32'(result.state_code), '0);
      end else begin
        want = step_results_q.pop_front();
        if (result.state_code !== want.state_code)
          report("state_code", 32'(result.state_code), 32'(want.state_code));
        if (result.run_status !== want.run_status)
          report("run_status", 32'(result.run_status), 32'(want.run_status));
        if (result.program_counter !== want.program_counter)
          report("program_counter", result.program_counter, want.program_counter);
        if (result.instruction !== want.instruction)
          report("instruction", result.instruction, want.instruction);
        if (result.bus_value !== want.bus_value)
          report("bus_value", result.bus_value, want.bus_value);
        if (result.memory_ready !== want.memory_ready)
          report("memory_ready", 32'(result.memory_ready), 32'(want.memory_ready));
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_each_op();
    test_random_programs();
    test_backpressure();
    test_stop_machine();
    item_valid <= 1'b0;
    while (step_results_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/mcc_pkg.sv
rtl/core/mcc_ram.sv
rtl/core/mcc_datapath.sv
rtl/core/mcc_ctrl.sv
rtl/core/multicycle_cpu_controller_unit.sv
sim/tb.sv
